@@ design/des_pkg.sv @@
// des_pkg: shared constants, types and permutation functions for the des core
// no dependencies
`default_nettype none
package des_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned CdW    = 28;
  localparam int unsigned SubkW  = 48;
  localparam int unsigned Rounds = 16;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  typedef struct packed {
    logic [HalfW-1:0] l;
    logic [HalfW-1:0] r;
    logic [CdW-1:0]   c;
    logic [CdW-1:0]   d;
    logic             dec;
  } round_t;

  typedef logic [7:0] tab64_t [64];

  localparam tab64_t TabIp = '{
    8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2, 8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
    8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6, 8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,  8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
    8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5, 8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

  localparam tab64_t TabFp = '{
    8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32, 8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
    8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30, 8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
    8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28, 8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
    8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26, 8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

  localparam logic [7:0] TabE [48] = '{
    8'd32,8'd1,8'd2,8'd3,8'd4,8'd5, 8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
    8'd8,8'd9,8'd10,8'd11,8'd12,8'd13, 8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
    8'd16,8'd17,8'd18,8'd19,8'd20,8'd21, 8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
    8'd24,8'd25,8'd26,8'd27,8'd28,8'd29, 8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

  localparam logic [7:0] TabP [32] = '{
    8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17, 8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
    8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,    8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

  localparam logic [7:0] TabPc1 [56] = '{
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9, 8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
    8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27, 8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
    8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15, 8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
    8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29, 8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

  localparam logic [7:0] TabPc2 [48] = '{
    8'd14,8'd17,8'd11,8'd24,8'd1,8'd5, 8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
    8'd23,8'd19,8'd12,8'd4,8'd26,8'd8, 8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
    8'd41,8'd52,8'd31,8'd37,8'd47,8'd55, 8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
    8'd44,8'd49,8'd39,8'd56,8'd34,8'd53, 8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

  // rotation amount per round, 1 = single shift
  localparam logic [Rounds-1:0] RotOne = 16'b1000_0001_0000_0011;

  localparam logic [3:0] TabS [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // table entries count from the msb, 1-based
  function automatic logic [63:0] perm_ip(input logic [63:0] src);
    logic [63:0] o;
    for (int k = 0; k < 64; k++) o[63-k] = src[64-int'(TabIp[k])];
    return o;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] src);
    logic [63:0] o;
    for (int k = 0; k < 64; k++) o[63-k] = src[64-int'(TabFp[k])];
    return o;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] src);
    logic [55:0] o;
    for (int k = 0; k < 56; k++) o[55-k] = src[64-int'(TabPc1[k])];
    return o;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] src);
    logic [47:0] o;
    for (int k = 0; k < 48; k++) o[47-k] = src[56-int'(TabPc2[k])];
    return o;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sk);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] o;
    logic [5:0]  six;
    for (int k = 0; k < 48; k++) x[47-k] = r[32-int'(TabE[k])];
    x = x ^ sk;
    for (int j = 0; j < 8; j++) begin
      six = x[47-6*j -: 6];
      s[31-4*j -: 4] = TabS[j][{six[5], six[0], six[4:1]}];
    end
    for (int k = 0; k < 32; k++) o[31-k] = s[32-int'(TabP[k])];
    return o;
  endfunction

endpackage
`default_nettype wire

@@ design/des_round.sv @@
// des_round: one registered feistel round with its key schedule step
// depends on des_pkg
`default_nettype none
module des_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  des_pkg::round_t     st_i,
  output logic                valid_o,
  output des_pkg::round_t     st_o
);
  localparam bit Single = des_pkg::RotOne[RoundIdx];
  // decrypt walks the schedule backwards: right rotations, undo after use
  localparam bit DecSingle = (RoundIdx == 0) ? 1'b0 :
                             des_pkg::RotOne[(des_pkg::Rounds - RoundIdx) % des_pkg::Rounds];

  logic [des_pkg::CdW-1:0] c_enc, d_enc, c_dec, d_dec, c_use, d_use;
  logic [des_pkg::CdW-1:0] c_nxt, d_nxt;
  des_pkg::round_t st_d, st_q;
  logic valid_q;

  always_comb begin
    c_enc = Single ? {st_i.c[26:0], st_i.c[27]} : {st_i.c[25:0], st_i.c[27:26]};
    d_enc = Single ? {st_i.d[26:0], st_i.d[27]} : {st_i.d[25:0], st_i.d[27:26]};
    // decrypt round 0 uses the pc1 value (rotations total 28)
    if (RoundIdx == 0) begin
      c_dec = st_i.c;
      d_dec = st_i.d;
    end else begin
      c_dec = DecSingle ? {st_i.c[0], st_i.c[27:1]} : {st_i.c[1:0], st_i.c[27:2]};
      d_dec = DecSingle ? {st_i.d[0], st_i.d[27:1]} : {st_i.d[1:0], st_i.d[27:2]};
    end
    c_use = st_i.dec ? c_dec : c_enc;
    d_use = st_i.dec ? d_dec : d_enc;
    c_nxt = c_use;
    d_nxt = d_use;
    st_d.l   = st_i.r;
    st_d.r   = st_i.l ^ des_pkg::feistel(st_i.r, des_pkg::perm_pc2({c_use, d_use}));
    st_d.c   = c_nxt;
    st_d.d   = d_nxt;
    st_d.dec = st_i.dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
endmodule
`default_nettype wire

@@ design/des_block_cipher_core.sv @@
// des_block_cipher_core: pipelined des engine, one block per cycle
// depends on des_pkg and des_round
// pipeline: a start beat reaches done_o through the input stage, 16 round stages and the output stage
// throughput: one block per cycle, busy is always low since every stage advances each cycle
// reset: asynchronous active low, clears all valid bits; payload registers are not reset
// the receiver cannot stall, a result shows on result_block_o for exactly one cycle with done_o
`default_nettype none
module des_block_cipher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] data_block_i,
  input  wire logic [63:0] cipher_key_i,
  input  wire logic        command_i,
  output logic             done_o,
  output logic [63:0]      result_block_o
);
  localparam int unsigned N = des_pkg::Rounds;

  // input stage: ip and pc1 registered
  des_pkg::round_t in_q, in_d;
  logic            in_vld_q;
  logic [55:0]     cd;
  logic [63:0]     ip_blk;

  logic            vld [N+1];
  des_pkg::round_t st  [N+1];

  logic            out_vld_q;
  logic [63:0]     out_q;

  assign busy = 1'b0;

  always_comb begin
    cd        = des_pkg::perm_pc1(cipher_key_i);
    ip_blk    = des_pkg::perm_ip(data_block_i);
    in_d.l    = ip_blk[63:32];
    in_d.r    = ip_blk[31:0];
    in_d.c    = cd[55:28];
    in_d.d    = cd[27:0];
    in_d.dec  = (command_i == des_pkg::CmdDecrypt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    // final swap r16||l16, then inverse ip
    out_q <= des_pkg::perm_fp({st[N].r, st[N].l});
  end

  assign vld[0] = in_vld_q;
  assign st[0]  = in_q;

  // one stage per round
  for (genvar g = 0; g < N; g++) begin : g_round
    des_round #(.RoundIdx(g)) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[g]),
      .st_i   (st[g]),
      .valid_o(vld[g+1]),
      .st_o   (st[g+1])
    );
  end

  assign done_o         = out_vld_q;
  assign result_block_o = out_q;

  // a valid round pipe output must show up as done through the output stage register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[N] |=> done_o) else $error("round pipe output lost");
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_vld_q) else $error("start beat not captured");
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld[N])) else $error("done without work");
endmodule
`default_nettype wire
